/* src/skm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword matcher package
// Shared constants, codes and the control bundle broadcast to the pattern cells.
// ----------------------------------------------------------------------------
package skm_pkg;

   localparam int DEF_NUM_PATTERNS = 16;
   localparam int DEF_MAX_LEN      = 32;

   localparam int ACTIVE_W   = 5;
   localparam int SLOT_W     = 4;
   localparam int POSITION_W = 5;
   localparam int BYTE_W     = 8;
   localparam int HIT_W      = 4;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_MATCH = 1'b1;

   typedef struct packed {
      logic                  fetch;
      logic                  load_commit;
      logic                  match_commit;
      logic                  clear_all;
      logic [SLOT_W-1:0]     slot;
      logic [POSITION_W-1:0] position;
      logic [BYTE_W-1:0]     data_byte;
      logic                  final_byte;
      logic [ACTIVE_W-1:0]   active_patterns;
   } cell_ctrl_type;

endpackage

/* src/skm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword matcher pattern cell
// Holds one pattern, its length and progress, and joins the priority chain.
// ----------------------------------------------------------------------------
module skm_cell
   import skm_pkg::*;
#(
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int CELL_INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic             found_in,
   input  logic [HIT_W-1:0] index_in,
   output logic             found_out,
   output logic [HIT_W-1:0] index_out
);

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W  = $clog2(MAX_LEN + 1);

   logic [BYTE_W-1:0] mem_ff [MAX_LEN];
   logic [BYTE_W-1:0] rd_ff;
   logic [ADDR_W-1:0] progress_ff, progress_in;
   logic [LEN_W-1:0]  length_ff, length_in;

   logic              selected;
   logic              active;
   logic [LEN_W-1:0]  progress_ext;
   logic [BYTE_W-1:0] expected;
   logic              equal;
   logic [LEN_W-1:0]  next_full;
   logic              done;
   logic [ADDR_W-1:0] write_addr;

   assign selected = (32'(ctrl.slot) == CELL_INDEX) && (32'(ctrl.position) < MAX_LEN);
   assign active   = CELL_INDEX < 32'(ctrl.active_patterns);
   assign write_addr = ADDR_W'(ctrl.position);

   assign progress_ext = LEN_W'(progress_ff);
   assign expected     = (progress_ext < length_ff) ? rd_ff : '0;
   assign equal        = ctrl.data_byte == expected;

   always_comb begin
      next_full = '0;
      if (equal) begin
         next_full = progress_ext + LEN_W'(1);
         if ((32'(next_full) >= MAX_LEN) && (next_full != length_ff)) begin
            next_full = '0;
         end
      end
   end

   assign done      = active && (next_full == length_ff);
   assign found_out = found_in || done;
   assign index_out = found_in ? index_in : HIT_W'(CELL_INDEX);

   always_comb begin
      progress_in = progress_ff;
      length_in   = length_ff;
      if (ctrl.load_commit && selected) begin
         progress_in = '0;
         if (ctrl.final_byte) begin
            length_in = LEN_W'(ctrl.position) + LEN_W'(1);
         end
      end else if (ctrl.match_commit) begin
         if (ctrl.clear_all) begin
            progress_in = '0;
         end else if (active) begin
            progress_in = ADDR_W'(next_full);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
         length_ff   <= '0;
      end else begin
         progress_ff <= progress_in;
         length_ff   <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_commit && selected) begin
         mem_ff[write_addr] <= ctrl.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fetch) begin
         rd_ff <= mem_ff[progress_ff];
      end
   end

endmodule

/* src/streaming_keyword_matcher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming keyword matcher
// Row of pattern cells that load keyword bytes and track stream matches.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports
//  req      in         req_valid, req_ready, req_action, req_slot, req_position,
//                      req_data_byte, req_final_byte
//  rsp      out        rsp_valid, rsp_ready, rsp_hit, rsp_hit_index
//  csr      in         csr_valid, csr_ready, csr_active_patterns
//
// On acceptance, each request's fields are registered and every cell reads
// its pattern byte at its progress; in the evaluate state the matcher then
// compares, walks the priority chain and updates the cells. The result register
// lets the next request enter while a result waits. A stalled result holds
// the evaluate state until the result register frees. Reset is synchronous
// and clears lengths, progress and the active count; pattern bytes are not cleared.
// ----------------------------------------------------------------------------
module streaming_keyword_matcher_top
   import skm_pkg::*;
#(
   parameter int NUM_PATTERNS = DEF_NUM_PATTERNS,
   parameter int MAX_LEN      = DEF_MAX_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [POSITION_W-1:0] req_position,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  req_final_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [HIT_W-1:0]      rsp_hit_index,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ACTIVE_W-1:0]   csr_active_patterns
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [ACTIVE_W-1:0]   active_ff, active_in;
   logic                  action_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [POSITION_W-1:0] position_ff;
   logic [BYTE_W-1:0]     data_ff;
   logic                  final_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [HIT_W-1:0]      rsp_index_ff;

   logic                  accept;
   logic                  commit;
   logic                  any_hit;
   cell_ctrl_type         ctrl;
   logic                  found [NUM_PATTERNS+1];
   logic [HIT_W-1:0]      index [NUM_PATTERNS+1];

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_ready);
   assign any_hit   = (action_ff == ACTION_MATCH) && found[NUM_PATTERNS];

   assign ctrl.fetch           = accept;
   assign ctrl.load_commit     = commit && (action_ff == ACTION_LOAD);
   assign ctrl.match_commit    = commit && (action_ff == ACTION_MATCH);
   assign ctrl.clear_all       = any_hit;
   assign ctrl.slot            = slot_ff;
   assign ctrl.position        = position_ff;
   assign ctrl.data_byte       = data_ff;
   assign ctrl.final_byte      = final_ff;
   assign ctrl.active_patterns = active_ff;

   assign found[0] = 1'b0;
   assign index[0] = '0;

   for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_cell
      skm_cell #(
         .MAX_LEN    (MAX_LEN),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .found_in  (found[i]),
         .index_in  (index[i]),
         .found_out (found[i+1]),
         .index_out (index[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign active_in    = (csr_valid && csr_ready) ? csr_active_patterns : active_ff;
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req_action;
         slot_ff     <= req_slot;
         position_ff <= req_position;
         data_ff     <= req_data_byte;
         final_ff    <= req_final_byte;
      end
      if (commit) begin
         rsp_hit_ff   <= any_hit;
         rsp_index_ff <= any_hit ? index[NUM_PATTERNS] : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_index = rsp_index_ff;

endmodule

/* tb/tb_streaming_keyword_matcher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming keyword matcher testbench
// Loads keyword patterns and streams characters through the matcher. Every
// accepted request is run through a local model of the pattern table, and
// each response is checked against the oldest prediction. Both sides stall
// at random, and one phase holds the response side off long enough to
// back the request side up.
// ----------------------------------------------------------------------------
module tb_streaming_keyword_matcher_top;
   import skm_pkg::*;

   localparam int NUM_PAT = DEF_NUM_PATTERNS;
   localparam int PAT_LEN = DEF_MAX_LEN;

   typedef struct packed {
      logic                  action;
      logic [SLOT_W-1:0]     slot;
      logic [POSITION_W-1:0] position;
      logic [BYTE_W-1:0]     data_byte;
      logic                  final_byte;
   } kw_request_type;

   typedef struct packed {
      logic             hit;
      logic [HIT_W-1:0] hit_index;
   } match_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_action;
   logic [SLOT_W-1:0]     req_slot;
   logic [POSITION_W-1:0] req_position;
   logic [BYTE_W-1:0]     req_data_byte;
   logic                  req_final_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_hit;
   logic [HIT_W-1:0]      rsp_hit_index;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [ACTIVE_W-1:0]   csr_active_patterns;

   logic [BYTE_W-1:0] kw_bytes [NUM_PAT][PAT_LEN];
   bit                kw_written [NUM_PAT][PAT_LEN];
   int                kw_length [NUM_PAT];
   int                kw_progress [NUM_PAT];
   int                active_count;

   match_result_type expected_hits [$];

   int  n_requests;
   int  n_matches;
   int  n_responses;
   int  n_hits;
   int  n_settings;
   int  n_errors;
   bit  tx_idle_on;
   bit  rx_idle_on;
   int  rx_hold_cycles;

   streaming_keyword_matcher_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_slot            (req_slot),
      .req_position        (req_position),
      .req_data_byte       (req_data_byte),
      .req_final_byte      (req_final_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_hit_index       (rsp_hit_index),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_active_patterns (csr_active_patterns)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("streaming_keyword_matcher_top: mismatch");
      $finish;
   end

   function automatic match_result_type predict_matcher(input kw_request_type r);
      match_result_type res;
      int               n;
      int               p;
      int               nxt;
      logic [7:0]       cmp;
      res = '0;
      if (r.action == ACTION_LOAD) begin
         kw_bytes[r.slot][r.position] = r.data_byte;
         kw_written[r.slot][r.position] = 1'b1;
         if (r.final_byte) begin
            kw_length[r.slot] = int'(r.position) + 1;
         end
         kw_progress[r.slot] = 0;
      end else begin
         n = (active_count > NUM_PAT) ? NUM_PAT : active_count;
         for (int i = 0; i < n && !res.hit; i++) begin
            p = kw_progress[i];
            cmp = (p < kw_length[i]) ? kw_bytes[i][p] : 8'h00;
            if (r.data_byte == cmp) begin
               nxt = p + 1;
               if (nxt >= PAT_LEN && nxt != kw_length[i]) begin
                  nxt = 0;
               end
            end else begin
               nxt = 0;
            end
            if (nxt == kw_length[i]) begin
               res.hit = 1'b1;
               res.hit_index = i[HIT_W-1:0];
            end else begin
               kw_progress[i] = nxt;
            end
         end
         if (res.hit) begin
            for (int i = 0; i < NUM_PAT; i++) begin
               kw_progress[i] = 0;
            end
         end
      end
      return res;
   endfunction

   function automatic bit prefix_loaded(input int s, input int pos);
      bit ok;
      ok = 1'b1;
      for (int k = 0; k < pos; k++) begin
         if (!kw_written[s][k]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [7:0] random_char();
      if ($urandom_range(0, 99) < 75) begin
         return 8'h61 + 8'($urandom_range(0, 3));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      n_errors++;
      if (n_errors <= 40) begin
         $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
      end
   endtask

   task automatic send_request(input kw_request_type r);
      int gap;
      gap = tx_idle_on ? int'($urandom_range(0, 9)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= r.action;
      req_slot       <= r.slot;
      req_position   <= r.position;
      req_data_byte  <= r.data_byte;
      req_final_byte <= r.final_byte;
      do @(posedge clock); while (!req_ready);
      expected_hits.push_back(predict_matcher(r));
      n_requests++;
      if (r.action == ACTION_MATCH) begin
         n_matches++;
      end
   endtask

   task automatic send_match(input logic [7:0] ch);
      kw_request_type r;
      r.action     = ACTION_MATCH;
      r.slot       = SLOT_W'($urandom_range(0, NUM_PAT - 1));
      r.position   = POSITION_W'($urandom_range(0, PAT_LEN - 1));
      r.data_byte  = ch;
      r.final_byte = 1'($urandom_range(0, 1));
      send_request(r);
   endtask

   task automatic send_load(input int s, input int pos, input logic [7:0] b,
                            input bit last);
      kw_request_type r;
      r.action     = ACTION_LOAD;
      r.slot       = SLOT_W'(s);
      r.position   = POSITION_W'(pos);
      r.data_byte  = b;
      r.final_byte = last;
      send_request(r);
   endtask

   task automatic load_keyword(input int s, input int len);
      for (int k = 0; k < len; k++) begin
         send_load(s, k, random_char(), k == len - 1);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_active(input int value);
      drain_results();
      csr_valid           <= 1'b1;
      csr_active_patterns <= ACTIVE_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      active_count = value;
      n_settings++;
   endtask

   task automatic test_directed_cases();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_match(8'h61);
      send_match(8'h00);
      write_active(0);
      send_match(8'hFF);
      send_load(0, 0, 8'h61, 1'b0);
      send_load(0, 1, 8'h62, 1'b1);
      write_active(1);
      send_match(8'h61);
      send_match(8'h62);
      // A failed second byte does not retry the same character at the start.
      send_match(8'h61);
      send_match(8'h61);
      send_match(8'h62);
      // Reloading a slot drops its partial progress.
      send_match(8'h61);
      send_load(0, 1, 8'h62, 1'b1);
      send_match(8'h62);
      send_load(15, 0, 8'hFF, 1'b1);
      send_load(7, 31, 8'h00, 1'b0);
      write_active(16);
      send_match(8'hFF);
      send_match(8'h00);
      write_active(31);
      send_match(8'h61);
      send_match(8'h62);
   endtask

   task automatic test_empty_pattern();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      write_active(2);
      // Slot one has no length: zeros walk its progress until it wraps.
      repeat (34) send_match(8'h00);
      send_match(8'h62);
      send_match(8'h00);
      send_match(8'h80);
   endtask

   task automatic test_fill_table();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b0;
      for (int s = 0; s < NUM_PAT; s++) begin
         if (s == 9) begin
            load_keyword(s, PAT_LEN);
         end else begin
            load_keyword(s, $urandom_range(1, 5));
         end
      end
   endtask

   task automatic test_random_stream();
      int settings [6];
      int goal;
      int n;
      int s;
      int pos;
      int pick;
      settings = '{16, 31, 1, 5, 0, 16};
      settings[4] = $urandom_range(0, 31);
      for (int round = 0; round < 6; round++) begin
         tx_idle_on = (round % 3) != 2;
         rx_idle_on = (round % 2) == 0;
         repeat ($urandom_range(1, 3)) begin
            s = $urandom_range(0, NUM_PAT - 1);
            load_keyword(s, ($urandom_range(0, 9) == 0) ? PAT_LEN : $urandom_range(1, 5));
         end
         write_active(settings[round]);
         n = (active_count > NUM_PAT) ? NUM_PAT : active_count;
         goal = n_requests + 95;
         while (n_requests < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && n > 0) begin
               s = $urandom_range(0, n - 1);
               for (int k = 0; k < kw_length[s]; k++) begin
                  send_match(kw_bytes[s][k]);
               end
            end else if (pick < 30) begin
               s   = $urandom_range(0, NUM_PAT - 1);
               pos = $urandom_range(0, PAT_LEN - 1);
               send_load(s, pos, random_char(),
                         $urandom_range(0, 1) && prefix_loaded(s, pos));
            end else if (pick < 40) begin
               send_match(8'($urandom_range(0, 255)));
            end else begin
               send_match(random_char());
            end
         end
      end
   endtask

   task automatic test_backpressure();
      int s;
      write_active(16);
      tx_idle_on     = 1'b0;
      rx_idle_on     = 1'b0;
      rx_hold_cycles = 300;
      repeat (40) begin
         if ($urandom_range(0, 3) == 0) begin
            s = $urandom_range(0, NUM_PAT - 1);
            for (int k = 0; k < kw_length[s]; k++) begin
               send_match(kw_bytes[s][k]);
            end
         end else begin
            send_match(random_char());
         end
      end
   endtask

   initial begin : response_side
      int n;
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            n = rx_hold_cycles;
            rx_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         stall = rx_idle_on ? int'($urandom_range(0, 9)) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      match_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_responses++;
         if (rsp_hit === 1'b1) begin
            n_hits++;
         end
         if (expected_hits.size() == 0) begin
            report_mismatch("response with no request outstanding",
                            {3'b0, rsp_hit, rsp_hit_index}, 8'h00);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_hit !== want.hit) begin
               report_mismatch("hit", {7'b0, rsp_hit}, {7'b0, want.hit});
            end
            if (rsp_hit_index !== want.hit_index) begin
               report_mismatch("hit_index", {4'b0, rsp_hit_index}, {4'b0, want.hit_index});
            end
         end
      end
   end

   initial begin : main
      req_valid           <= 1'b0;
      req_action          <= ACTION_LOAD;
      req_slot            <= '0;
      req_position        <= '0;
      req_data_byte       <= '0;
      req_final_byte      <= 1'b0;
      csr_valid           <= 1'b0;
      csr_active_patterns <= '0;
      for (int s = 0; s < NUM_PAT; s++) begin
         kw_length[s]   = 0;
         kw_progress[s] = 0;
         for (int k = 0; k < PAT_LEN; k++) begin
            kw_bytes[s][k]   = 8'h00;
            kw_written[s][k] = 1'b0;
         end
      end
      active_count   = 0;
      n_requests     = 0;
      n_matches      = 0;
      n_responses    = 0;
      n_hits         = 0;
      n_settings     = 0;
      n_errors       = 0;
      rx_hold_cycles = 0;
      tx_idle_on     = 1'b0;
      rx_idle_on     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_empty_pattern();
      test_fill_table();
      test_random_stream();
      test_backpressure();
      drain_results();

      $display("Covered %0d requests (%0d characters, %0d loads) under %0d active settings.",
               n_requests, n_matches, n_requests - n_matches, n_settings);
      $display("Checked %0d responses, %0d of them keyword hits, with %0d errors.",
               n_responses, n_hits, n_errors);
      if (n_errors == 0 && expected_hits.size() == 0) begin
         $display("streaming_keyword_matcher_top: match");
      end else begin
         $display("streaming_keyword_matcher_top: mismatch");
      end
      $finish;
   end

endmodule
